FILE: hw/rtl/prewitt_gradient_magnitude_top_macros.svh
// Assertion macros for the Prewitt gradient magnitude block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef PREWITT_GRADIENT_MAGNITUDE_TOP_MACROS_SVH
`define PREWITT_GRADIENT_MAGNITUDE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PRW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prw assertion failed");
`define PRW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prw assertion failed");
`else
`define PRW_ASSERT_NOW(label, ante, cons)
`define PRW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/prw_pkg.sv
package prw_pkg;

    localparam int DEF_MAX_LINE   = 512;
    localparam int DEF_MAX_LINES  = 512;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int CFG_W      = 10;
    localparam int CFG_RESET  = 512;
    localparam int MIN_SIZE   = 3;
    localparam int MAG_W      = 11;
    localparam int POS_OUT_W  = 9;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_FRAME_COLS = 1'b0,
        REG_FRAME_ROWS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
    } frame_size_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic shift;
        logic grad;
        logic square;
        logic sum;
        logic root_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic root_last;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/prw_regs.sv
module prw_regs
    import prw_pkg::*;
#(
    parameter int MAX_LINE  = DEF_MAX_LINE,
    parameter int MAX_LINES = DEF_MAX_LINES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output frame_size_t           size
);

    localparam int RESET_COLS = (CFG_RESET > MAX_LINE) ? MAX_LINE : CFG_RESET;
    localparam int RESET_ROWS = (CFG_RESET > MAX_LINES) ? MAX_LINES : CFG_RESET;

    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] cols_next;
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] rows_next;
    logic             wr_en;
    reg_index_t       index;

    // Values outside the legal range are pulled to the nearest limit.
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int unsigned hi);
        logic [CFG_W-1:0] r;
        if (v < CFG_W'(MIN_SIZE))
        begin
            r = CFG_W'(MIN_SIZE);
        end
        else if (32'(v) > hi)
        begin
            r = CFG_W'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[2]);

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_FRAME_COLS: cols_next = clamp_size(pwdata[CFG_W-1:0], MAX_LINE);
                REG_FRAME_ROWS: rows_next = clamp_size(pwdata[CFG_W-1:0], MAX_LINES);
                default:        cols_next = cols_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_FRAME_COLS: prdata = APB_DATA_W'(cols_reg);
            REG_FRAME_ROWS: prdata = APB_DATA_W'(rows_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(RESET_COLS);
            rows_reg <= CFG_W'(RESET_ROWS);
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    assign size.cols = cols_reg;
    assign size.rows = rows_reg;

endmodule

FILE: hw/rtl/prw_ctrl.sv
module prw_ctrl
    import prw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:  state_next = status.emit ? ST_GRAD : ST_IDLE;
            ST_GRAD:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (status.root_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_SHIFT:  cmd.shift     = 1'b1;
            ST_GRAD:   cmd.grad      = 1'b1;
            ST_SQUARE: cmd.square    = 1'b1;
            ST_SUM:    cmd.sum       = 1'b1;
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_DONE:   cmd.load_out  = !status.out_busy;
            default:   cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/prw_dp.sv
module prw_dp
    import prw_pkg::*;
#(
    parameter int MAX_LINE   = DEF_MAX_LINE,
    parameter int MAX_LINES  = DEF_MAX_LINES,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  frame_size_t           size,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic                  frame_start,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [MAG_W-1:0]      magnitude,
    output logic [POS_OUT_W-1:0]  out_row,
    output logic [POS_OUT_W-1:0]  out_col,
    output logic                  frame_last
);

    localparam int COL_W     = $clog2(MAX_LINE);
    localparam int ROW_W     = $clog2(MAX_LINES);
    localparam int POS_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W     = ((POS_MAX_W > CFG_W) ? POS_MAX_W : CFG_W) + 1;
    localparam int G_W       = PIXEL_BITS + 3;
    localparam int SQ1_W     = 2 * PIXEL_BITS + 4;
    localparam int RT_W      = PIXEL_BITS + 3;
    localparam int SQ_W      = 2 * RT_W;
    localparam int REM_W     = RT_W + 2;
    localparam int CNT_W     = $clog2(RT_W);

    // Frame position and the item under work.
    logic [COL_W-1:0]      pos_col_reg;
    logic [ROW_W-1:0]      pos_row_reg;
    logic [COL_W-1:0]      pos_col_next;
    logic [ROW_W-1:0]      pos_row_next;
    logic [COL_W-1:0]      col_sel;
    logic [ROW_W-1:0]      row_sel;
    logic                  col_wrap;
    logic                  row_wrap;
    logic [COL_W-1:0]      cur_col_reg;
    logic [ROW_W-1:0]      cur_row_reg;
    logic [PIXEL_BITS-1:0] px_reg;
    logic                  emit_reg;
    logic                  last_reg;

    // Line stores and the window.
    logic [PIXEL_BITS-1:0] upper_mem [MAX_LINE];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_LINE];
    logic [PIXEL_BITS-1:0] up_rd_reg;
    logic [PIXEL_BITS-1:0] lo_rd_reg;
    logic [PIXEL_BITS-1:0] win_reg [3][3];

    // Gradient and square root.
    logic signed [G_W-1:0]   gx_next;
    logic signed [G_W-1:0]   gy_next;
    logic signed [G_W-1:0]   gx_reg;
    logic signed [G_W-1:0]   gy_reg;
    logic signed [2*G_W-1:0] gx_sq;
    logic signed [2*G_W-1:0] gy_sq;
    logic [SQ1_W-1:0]        sqx_reg;
    logic [SQ1_W-1:0]        sqy_reg;
    logic [SQ_W-1:0]         rad_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [RT_W-1:0]         root_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        trial;
    logic                    root_bit;

    // Output register.
    logic                 out_valid_reg;
    logic [MAG_W-1:0]     mag_out_reg;
    logic [POS_OUT_W-1:0] row_out_reg;
    logic [POS_OUT_W-1:0] col_out_reg;
    logic                 last_out_reg;

    assign col_sel  = frame_start ? '0 : pos_col_reg;
    assign row_sel  = frame_start ? '0 : pos_row_reg;
    assign col_wrap = (CMP_W'(col_sel) + CMP_W'(1)) >= CMP_W'(size.cols);
    assign row_wrap = (CMP_W'(row_sel) + CMP_W'(1)) >= CMP_W'(size.rows);

    always_comb
    begin
        pos_col_next = col_sel + COL_W'(1);
        pos_row_next = row_sel;
        if (col_wrap)
        begin
            pos_col_next = '0;
            pos_row_next = row_wrap ? '0 : row_sel + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_col_reg <= '0;
            pos_row_reg <= '0;
        end
        else if (cmd.accept)
        begin
            pos_col_reg <= pos_col_next;
            pos_row_reg <= pos_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_col_reg <= col_sel;
            cur_row_reg <= row_sel;
            px_reg      <= pixel;
            emit_reg    <= (row_sel >= ROW_W'(2)) && (col_sel >= COL_W'(2));
            last_reg    <= col_wrap && row_wrap;
        end
    end

    // Both stores are read when a pixel is taken and written in the cycle after.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            up_rd_reg <= upper_mem[col_sel];
            lo_rd_reg <= lower_mem[col_sel];
        end
        if (cmd.shift)
        begin
            upper_mem[cur_col_reg] <= lo_rd_reg;
            lower_mem[cur_col_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_rd_reg;
            win_reg[1][2] <= lo_rd_reg;
            win_reg[2][2] <= px_reg;
        end
    end

    // The right column minus the left column, and the bottom row minus the top row.
    always_comb
    begin
        gx_next = '0;
        gy_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            gx_next = gx_next + $signed({3'b000, win_reg[i][2]})
                              - $signed({3'b000, win_reg[i][0]});
            gy_next = gy_next + $signed({3'b000, win_reg[2][i]})
                              - $signed({3'b000, win_reg[0][i]});
        end
    end

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    // Restoring square root, two radicand bits per step.
    assign rem_sh   = {rem_reg[REM_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign root_bit = rem_sh >= trial;

    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.square)
        begin
            sqx_reg <= gx_sq[SQ1_W-1:0];
            sqy_reg <= gy_sq[SQ1_W-1:0];
        end
        if (cmd.sum)
        begin
            rad_reg  <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= root_bit ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[RT_W-2:0], root_bit};
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            mag_out_reg  <= MAG_W'(root_reg);
            row_out_reg  <= POS_OUT_W'(cur_row_reg) - POS_OUT_W'(2);
            col_out_reg  <= POS_OUT_W'(cur_col_reg) - POS_OUT_W'(2);
            last_out_reg <= last_reg;
        end
    end

    assign status.emit      = emit_reg;
    assign status.root_last = cnt_reg == CNT_W'(RT_W - 1);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign magnitude  = mag_out_reg;
    assign out_row    = row_out_reg;
    assign out_col    = col_out_reg;
    assign frame_last = last_out_reg;

endmodule

FILE: hw/rtl/prewitt_gradient_magnitude_top.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+--------------------------------------
// input     | in        | in_valid, in_ready  | pixel, frame_start
// output    | out       | out_valid, out_ready| magnitude, out_row, out_col, frame_last
// config    | in        | APB write, pready=1 | frame_cols at 0x0, frame_rows at 0x4
//
// A pixel that completes a full 3x3 window goes through the shift, gradient, square,
// sum, root and done states before the next input slot; a border pixel only shifts.
// The cost of a full window is set by the iterative square root, which resolves
// one result bit per cycle. The block works on one pixel at a time.
// The output register lets the next pixel in while a result waits; a result that
// finds it still full holds the block until the earlier one is taken.
// rst_n clears the position, window, control state and sets both sizes to 512,
// or to MAX_LINE and MAX_LINES where those are smaller; the line stores are not cleared.
`include "prewitt_gradient_magnitude_top_macros.svh"

module prewitt_gradient_magnitude_top
    import prw_pkg::*;
#(
    parameter int MAX_LINE   = DEF_MAX_LINE,
    parameter int MAX_LINES  = DEF_MAX_LINES,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [MAG_W-1:0]      magnitude,
    output logic [POS_OUT_W-1:0]  out_row,
    output logic [POS_OUT_W-1:0]  out_col,
    output logic                  frame_last
);

    frame_size_t size;
    dp_cmd_t     cmd;
    dp_status_t  status;

    prw_regs #(
        .MAX_LINE  (MAX_LINE),
        .MAX_LINES (MAX_LINES)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .size    (size)
    );

    prw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    prw_dp #(
        .MAX_LINE   (MAX_LINE),
        .MAX_LINES  (MAX_LINES),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .size        (size),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .magnitude   (magnitude),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_last  (frame_last)
    );

    // In the cycle after a pixel transfer the block is busy.
    `PRW_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
    // A new result is only loaded by a pixel in work, never from the idle state.
    `PRW_ASSERT_NOW(a_result_from_work, $rose(out_valid), !$past(in_ready))

endmodule
